// ===== sv/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

	// field widths
	localparam int COORD_BITS = 16;
	localparam int FRAC_BITS  = 4;
	localparam int OUT_W      = 22;

	// working widths
	localparam int EXT_W    = COORD_BITS + 2;
	localparam int SQ_W     = 2 * COORD_BITS;
	localparam int SUM_W    = SQ_W + 1;
	localparam int SCALED_W = SUM_W + 2 * FRAC_BITS;
	localparam int ROOT_W   = (SCALED_W + 1) / 2;
	localparam int RAD_W    = 2 * ROOT_W;
	localparam int REM_W    = ROOT_W + 2;

	// mode code carried in cmd
	typedef enum logic {
		CMD_BOX    = 1'b0,
		CMD_CIRCLE = 1'b1
	} cmd_t;

	// state handed from one root cell to the next
	typedef struct packed {
		logic [REM_W-1:0]      rem;
		logic [ROOT_W-1:0]     root;
		logic [RAD_W-1:0]      rad;
		logic                  circle_mode;
		logic [COORD_BITS-1:0] radius;
	} cbd_cell_t;

endpackage

`default_nettype wire

// ===== sv/cbd_query_if.sv =====
`default_nettype none

interface cbd_query_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  cmd;
	logic signed [cbd_pkg::COORD_BITS-1:0] circle_x;
	logic signed [cbd_pkg::COORD_BITS-1:0] circle_y;
	logic        [cbd_pkg::COORD_BITS-1:0] radius;
	logic signed [cbd_pkg::COORD_BITS-1:0] other_x;
	logic signed [cbd_pkg::COORD_BITS-1:0] other_y;
	logic        [cbd_pkg::COORD_BITS-1:0] box_width;
	logic        [cbd_pkg::COORD_BITS-1:0] box_height;

	modport source (
		output valid, cmd, circle_x, circle_y, radius, other_x, other_y, box_width, box_height,
		input  ready
	);
	modport sink (
		input  valid, cmd, circle_x, circle_y, radius, other_x, other_y, box_width, box_height,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/cbd_result_if.sv =====
`default_nettype none

interface cbd_result_if;
	logic                             valid;
	logic                             ready;
	logic signed [cbd_pkg::OUT_W-1:0] distance_q4;

	modport source (
		output valid, distance_q4,
		input  ready
	);
	modport sink (
		input  valid, distance_q4,
		output ready
	);
endinterface

`default_nettype wire

// ===== sv/circle_box_distance_unit.sv =====
`default_nettype none

// Circle distance unit: per query, in box mode (cmd 0) the circle center is
// clamped into the box span on each axis and the result is the floored Q4
// distance from center to that point minus the radius, negative on overlap;
// in circle mode (cmd 1) it is the floored Q4 center-to-center distance.
// One query is accepted every cycle while the result side keeps up. A query
// passes through 25 register stages: three front stages (clamp, squares, sum),
// one root cell per root bit (21 cells, one digit each) and one output stage
// for the radius subtraction. Stages hold their item under backpressure and
// empty stages fill, so input stalls only when every stage is full.
module circle_box_distance_unit (
	input  wire logic    clk,
	input  wire logic    arst_n,
	cbd_query_if.sink    query,
	cbd_result_if.source result
);

	logic                             chain_valid [0:cbd_pkg::ROOT_W];
	logic                             chain_ready [0:cbd_pkg::ROOT_W];
	cbd_pkg::cbd_cell_t               chain_cell  [0:cbd_pkg::ROOT_W];
	logic                             valid_q;
	logic signed [cbd_pkg::OUT_W-1:0] distance_q;
	logic        [cbd_pkg::OUT_W-1:0] root_ext, rad_ext, dist_nxt;

	// clamp, square and sum
	cbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.query    (query),
		.dn_valid (chain_valid[0]),
		.dn_ready (chain_ready[0]),
		.dn_cell  (chain_cell[0])
	);

	// square root, one digit per cell
	for (genvar i = 0; i < cbd_pkg::ROOT_W; i++) begin : g_cell
		cbd_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (chain_valid[i]),
			.up_ready (chain_ready[i]),
			.up_cell  (chain_cell[i]),
			.dn_valid (chain_valid[i+1]),
			.dn_ready (chain_ready[i+1]),
			.dn_cell  (chain_cell[i+1])
		);
	end

	// subtract the scaled radius in box mode
	always_comb begin
		root_ext = cbd_pkg::OUT_W'(chain_cell[cbd_pkg::ROOT_W].root);
		rad_ext  = cbd_pkg::OUT_W'(chain_cell[cbd_pkg::ROOT_W].radius) << cbd_pkg::FRAC_BITS;
		if (chain_cell[cbd_pkg::ROOT_W].circle_mode == cbd_pkg::CMD_CIRCLE) begin
			dist_nxt = root_ext;
		end else begin
			dist_nxt = root_ext - rad_ext;
		end
	end

	assign chain_ready[cbd_pkg::ROOT_W] = !valid_q || result.ready;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (chain_ready[cbd_pkg::ROOT_W]) begin
			valid_q <= chain_valid[cbd_pkg::ROOT_W];
		end
	end

	always_ff @(posedge clk) begin
		if (chain_ready[cbd_pkg::ROOT_W] && chain_valid[cbd_pkg::ROOT_W]) begin
			distance_q <= $signed(dist_nxt);
		end
	end

	assign result.valid       = valid_q;
	assign result.distance_q4 = distance_q;

`ifndef NO_ASSERTIONS
	// input stalls only when the result side is blocked
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!query.ready |-> result.valid && !result.ready)
		else $error("input stalled while output free");
`endif

endmodule

`default_nettype wire

// ===== sv/cbd_front.sv =====
`default_nettype none

module cbd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	cbd_query_if.sink          query,
	output logic               dn_valid,
	input  wire logic          dn_ready,
	output cbd_pkg::cbd_cell_t dn_cell
);

	logic                                  v_s1, v_s2, v_s3;
	logic                                  r1, r2, r3;
	logic signed [cbd_pkg::EXT_W-1:0]      cx, cy, ox, oy, hx, hy, px, py, dx, dy;
	logic        [cbd_pkg::EXT_W-1:0]      mx, my;
	logic        [cbd_pkg::COORD_BITS-1:0] ax_s1, ay_s1;
	logic        [cbd_pkg::SQ_W-1:0]       sqx_s2, sqy_s2;
	logic        [cbd_pkg::SUM_W-1:0]      sum_s3;
	logic                                  mode_s1, mode_s2, mode_s3;
	logic        [cbd_pkg::COORD_BITS-1:0] rad_s1, rad_s2, rad_s3;

	// per-stage ready, a stage moves when it is empty or its successor takes
	assign r3          = !v_s3 || dn_ready;
	assign r2          = !v_s2 || r3;
	assign r1          = !v_s1 || r2;
	assign query.ready = r1;

	// clamp the center into the box span, or take the second center
	always_comb begin
		cx = cbd_pkg::EXT_W'(query.circle_x);
		cy = cbd_pkg::EXT_W'(query.circle_y);
		ox = cbd_pkg::EXT_W'(query.other_x);
		oy = cbd_pkg::EXT_W'(query.other_y);
		hx = ox + $signed(cbd_pkg::EXT_W'(query.box_width));
		hy = oy + $signed(cbd_pkg::EXT_W'(query.box_height));
		if (query.cmd == cbd_pkg::CMD_CIRCLE) begin
			px = ox;
			py = oy;
		end else begin
			px = (cx < ox) ? ox : ((cx > hx) ? hx : cx);
			py = (cy < oy) ? oy : ((cy > hy) ? hy : cy);
		end
		dx = px - cx;
		dy = py - cy;
		mx = dx[cbd_pkg::EXT_W-1] ? cbd_pkg::EXT_W'(-dx) : cbd_pkg::EXT_W'(dx);
		my = dy[cbd_pkg::EXT_W-1] ? cbd_pkg::EXT_W'(-dy) : cbd_pkg::EXT_W'(dy);
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (r1) v_s1 <= query.valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
		end
	end

	// stage 1: offsets
	always_ff @(posedge clk) begin
		if (r1 && query.valid) begin
			ax_s1   <= mx[cbd_pkg::COORD_BITS-1:0];
			ay_s1   <= my[cbd_pkg::COORD_BITS-1:0];
			mode_s1 <= query.cmd;
			rad_s1  <= query.radius;
		end
	end

	// stage 2: squares
	always_ff @(posedge clk) begin
		if (r2 && v_s1) begin
			sqx_s2  <= cbd_pkg::SQ_W'(ax_s1) * cbd_pkg::SQ_W'(ax_s1);
			sqy_s2  <= cbd_pkg::SQ_W'(ay_s1) * cbd_pkg::SQ_W'(ay_s1);
			mode_s2 <= mode_s1;
			rad_s2  <= rad_s1;
		end
	end

	// stage 3: sum of squares
	always_ff @(posedge clk) begin
		if (r3 && v_s2) begin
			sum_s3  <= cbd_pkg::SUM_W'(sqx_s2) + cbd_pkg::SUM_W'(sqy_s2);
			mode_s3 <= mode_s2;
			rad_s3  <= rad_s2;
		end
	end

	// scaled radicand enters the first root cell
	always_comb begin
		dn_cell             = '0;
		dn_cell.rad         = cbd_pkg::RAD_W'(sum_s3) << (2 * cbd_pkg::FRAC_BITS);
		dn_cell.circle_mode = mode_s3;
		dn_cell.radius      = rad_s3;
	end
	assign dn_valid = v_s3;

endmodule

`default_nettype wire

// ===== sv/cbd_sqrt_cell.sv =====
`default_nettype none

module cbd_sqrt_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                up_valid,
	output logic                     up_ready,
	input  wire cbd_pkg::cbd_cell_t  up_cell,
	output logic                     dn_valid,
	input  wire logic                dn_ready,
	output cbd_pkg::cbd_cell_t       dn_cell
);

	logic                     valid_q;
	cbd_pkg::cbd_cell_t       cell_q;
	cbd_pkg::cbd_cell_t       nxt;
	logic [cbd_pkg::REM_W-1:0] rem_shift, trial;
	logic                     take;

	assign up_ready = !valid_q || dn_ready;

	// one root digit: bring down two radicand bits, try to subtract
	always_comb begin
		rem_shift = {up_cell.rem[cbd_pkg::REM_W-3:0], up_cell.rad[cbd_pkg::RAD_W-1 -: 2]};
		trial     = {up_cell.root, 2'b01};
		take      = rem_shift >= trial;
		nxt       = up_cell;
		nxt.rem   = take ? (rem_shift - trial) : rem_shift;
		nxt.root  = {up_cell.root[cbd_pkg::ROOT_W-2:0], take};
		nxt.rad   = {up_cell.rad[cbd_pkg::RAD_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			cell_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_cell  = cell_q;

`ifndef NO_ASSERTIONS
	// partial remainder never exceeds twice the partial root
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> ((cbd_pkg::REM_W+1)'(cell_q.rem) <= (cbd_pkg::REM_W+1)'({cell_q.root, 1'b0})))
		else $error("root cell remainder out of bound");

	// a blocked cell keeps its item
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !dn_ready |=> valid_q && $stable(cell_q))
		else $error("root cell lost a stalled item");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		cbd_pkg::cmd_t                         cmd;
		logic signed [cbd_pkg::COORD_BITS-1:0] circle_x;
		logic signed [cbd_pkg::COORD_BITS-1:0] circle_y;
		logic        [cbd_pkg::COORD_BITS-1:0] radius;
		logic signed [cbd_pkg::COORD_BITS-1:0] other_x;
		logic signed [cbd_pkg::COORD_BITS-1:0] other_y;
		logic        [cbd_pkg::COORD_BITS-1:0] box_width;
		logic        [cbd_pkg::COORD_BITS-1:0] box_height;
	} query_t;

	logic clk;
	logic arst_n;
	bit   idle_en;
	int   mismatch_count;

	logic signed [cbd_pkg::OUT_W-1:0] pending_distances[$];
	logic signed [cbd_pkg::OUT_W-1:0] want_distance;

	cbd_query_if  query();
	cbd_result_if result();

	circle_box_distance_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query),
		.result (result)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	// floor of the integer square root, one result bit at a time
	function automatic longint unsigned floor_root(longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	// clamp a coordinate into [lo, lo + size]
	function automatic longint clamp_to_span(longint c, longint lo, longint size);
		if (c < lo)
			return lo;
		if (c > lo + size)
			return lo + size;
		return c;
	endfunction

	// expected q4 distance for one query
	function automatic logic signed [cbd_pkg::OUT_W-1:0] predict_distance(query_t q);
		longint          cx, cy, px, py, dx, dy, d;
		longint unsigned sum_sq;
		cx = q.circle_x;
		cy = q.circle_y;
		if (q.cmd == cbd_pkg::CMD_CIRCLE) begin
			px = q.other_x;
			py = q.other_y;
		end else begin
			px = clamp_to_span(cx, q.other_x, longint'(q.box_width));
			py = clamp_to_span(cy, q.other_y, longint'(q.box_height));
		end
		dx = px - cx;
		dy = py - cy;
		// offsets stay within 17 bits here, so the scaled sum never saturates
		sum_sq = longint'(dx * dx + dy * dy);
		d = longint'(floor_root(sum_sq << (2 * cbd_pkg::FRAC_BITS)));
		if (q.cmd == cbd_pkg::CMD_BOX)
			d -= longint'(q.radius) << cbd_pkg::FRAC_BITS;
		return d[cbd_pkg::OUT_W-1:0];
	endfunction

	function automatic query_t make_query(cbd_pkg::cmd_t cmd, int cx, int cy, int r,
			int ox, int oy, int w, int h);
		query_t q;
		q.cmd        = cmd;
		q.circle_x   = 16'(cx);
		q.circle_y   = 16'(cy);
		q.radius     = 16'(r);
		q.other_x    = 16'(ox);
		q.other_y    = 16'(oy);
		q.box_width  = 16'(w);
		q.box_height = 16'(h);
		return q;
	endfunction

	// field value biased toward extremes and small magnitudes
	function automatic logic [cbd_pkg::COORD_BITS-1:0] pick_field();
		case ($urandom_range(0, 11))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			4, 5: return 16'($urandom_range(0, 255) - 128);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic query_t random_query(cbd_pkg::cmd_t cmd);
		query_t q;
		q.cmd        = cmd;
		q.circle_x   = pick_field();
		q.circle_y   = pick_field();
		q.radius     = pick_field();
		q.other_x    = pick_field();
		q.other_y    = pick_field();
		q.box_width  = pick_field();
		q.box_height = pick_field();
		// place the other shape close to the center a good part of the time
		if ($urandom_range(0, 2) == 0) begin
			q.other_x = q.circle_x - 16'($urandom_range(0, 300));
			q.other_y = q.circle_y - 16'($urandom_range(0, 300));
			q.box_width  = 16'($urandom_range(0, 600));
			q.box_height = 16'($urandom_range(0, 600));
		end
		return q;
	endfunction

	// drive one item and wait until it is taken
	task automatic send_query(query_t q);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			query.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		query.valid      <= 1'b1;
		query.cmd        <= q.cmd;
		query.circle_x   <= q.circle_x;
		query.circle_y   <= q.circle_y;
		query.radius     <= q.radius;
		query.other_x    <= q.other_x;
		query.other_y    <= q.other_y;
		query.box_width  <= q.box_width;
		query.box_height <= q.box_height;
		do
			@(posedge clk);
		while (!query.ready);
		pending_distances.push_back(predict_distance(q));
		@(negedge clk);
	endtask

	task automatic note_mismatch(string what, logic signed [cbd_pkg::OUT_W-1:0] exp_v,
			logic signed [cbd_pkg::OUT_W-1:0] got_v);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t: %s: expected %0d got %0d", $realtime, what, exp_v, got_v);
	endtask

	// result stalls in random bursts
	initial begin
		int stall_left;
		stall_left = 0;
		result.ready = 1'b1;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				result.ready <= 1'b0;
				stall_left--;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				result.ready <= 1'b0;
				stall_left = $urandom_range(0, 4);
			end else begin
				result.ready <= 1'b1;
			end
		end
	end

	// compare each result item with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result.valid && result.ready) begin
			if (pending_distances.size() == 0) begin
				note_mismatch("unexpected distance item", 'x, result.distance_q4);
			end else begin
				want_distance = pending_distances.pop_front();
				if (result.distance_q4 !== want_distance)
					note_mismatch("distance_q4", want_distance, result.distance_q4);
			end
		end
	end

	// edges of the ranges, overlap, degenerate boxes, both modes
	task automatic test_directed();
		send_query(make_query(cbd_pkg::CMD_BOX, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(cbd_pkg::CMD_BOX, 10, 10, 5, 0, 0, 100, 100));
		send_query(make_query(cbd_pkg::CMD_BOX, 0, 0, 0, 3, 4, 0, 0));
		send_query(make_query(cbd_pkg::CMD_BOX, -7, 20, 3, 0, -5, 0, 50));
		send_query(make_query(cbd_pkg::CMD_BOX, 5, 9, 1, -20, 2, 60, 0));
		send_query(make_query(cbd_pkg::CMD_BOX, -32768, -32768, 0, 32767, 32767,
			65535, 65535));
		send_query(make_query(cbd_pkg::CMD_BOX, 32767, 32767, 0, -32768, -32768, 0, 0));
		send_query(make_query(cbd_pkg::CMD_BOX, 100, -100, 65535, -32768, -32768,
			65535, 65535));
		send_query(make_query(cbd_pkg::CMD_BOX, 32767, 32767, 65535, 32767, 32767,
			65535, 65535));
		send_query(make_query(cbd_pkg::CMD_BOX, -32768, 32767, 65535, 32767, -32768,
			0, 0));
		send_query(make_query(cbd_pkg::CMD_BOX, 1, 1, 0, 0, 0, 0, 0));
		send_query(make_query(cbd_pkg::CMD_BOX, 200, 300, 7, 0, 0, 100, 100));
		send_query(make_query(cbd_pkg::CMD_BOX, -1, -1, 1, -1, -1, 0, 0));
		send_query(make_query(cbd_pkg::CMD_CIRCLE, 0, 0, 0, 0, 0, 0, 0));
		send_query(make_query(cbd_pkg::CMD_CIRCLE, -32768, -32768, 0, 32767, 32767,
			0, 0));
		send_query(make_query(cbd_pkg::CMD_CIRCLE, 32767, -32768, 65535, -32768, 32767,
			65535, 65535));
		send_query(make_query(cbd_pkg::CMD_CIRCLE, 0, 0, 65535, 3, 4, 65535, 65535));
		send_query(make_query(cbd_pkg::CMD_CIRCLE, 0, 0, 12, 1, 1, 0, 0));
		send_query(make_query(cbd_pkg::CMD_CIRCLE, -5, 7, 0, -5, 7, 65535, 0));
		send_query(make_query(cbd_pkg::CMD_CIRCLE, 32767, 0, 0, -32768, 0, 0, 0));
	endtask

	task automatic test_random_box();
		repeat (700) send_query(random_query(cbd_pkg::CMD_BOX));
	endtask

	task automatic test_random_circle();
		repeat (400) send_query(random_query(cbd_pkg::CMD_CIRCLE));
	endtask

	task automatic test_random_mixed();
		repeat (550) send_query(random_query(cbd_pkg::cmd_t'($urandom_range(0, 1))));
	endtask

	// back to back items with the result side always ready
	task automatic test_full_rate();
		idle_en = 1'b0;
		repeat (300) send_query(random_query(cbd_pkg::cmd_t'($urandom_range(0, 1))));
	endtask

	// main sequence
	initial begin
		mismatch_count   = 0;
		idle_en          = 1'b1;
		arst_n           = 1'b0;
		query.valid      = 1'b0;
		query.cmd        = 1'b0;
		query.circle_x   = '0;
		query.circle_y   = '0;
		query.radius     = '0;
		query.other_x    = '0;
		query.other_y    = '0;
		query.box_width  = '0;
		query.box_height = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_random_box();
		test_random_circle();
		test_random_mixed();
		test_full_rate();
		query.valid <= 1'b0;

		// drain the pipeline, then give stray items a chance to show up
		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

`default_nettype wire
